FILE: sv/conv5_pkg.sv
package conv5_pkg;

  // Kernel geometry and arithmetic
  localparam int KERNEL_SIZE    = 5;
  localparam int KRAD           = KERNEL_SIZE / 2;
  localparam int KTAPS          = KERNEL_SIZE * KERNEL_SIZE;
  localparam int COEF_FRAC_BITS = 12;

  // Image limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 5;
  localparam int DIM_RESET  = 256;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int IDX_W  = 5;
  localparam int CMD_W  = 2;
  localparam int DIM_W  = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int PIX_MAX = (1 << PIX_W) - 1;

  localparam int IN_TDATA_W  = ((PIX_W + IDX_W + COEF_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = PIX_W;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Line buffer: one entry per column, holding the previous KERNEL_SIZE-1 rows
  localparam int LB_W = (KERNEL_SIZE - 1) * PIX_W;

  // Datapath widths
  localparam int PROD_W   = PIX_W + 1 + COEF_W;
  localparam int ROWSUM_W = PROD_W + $clog2(KERNEL_SIZE);
  localparam int SUM_W    = ROWSUM_W + $clog2(KERNEL_SIZE);
  localparam int SH_W     = SUM_W - COEF_FRAC_BITS;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int USED_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

  typedef struct packed {
    logic present;
    logic out_valid;
    logic out_last;
    logic interior;
  } meta_t;

  typedef struct packed {
    meta_t                    meta;
    logic                     pix_wr;
    logic [PIX_W-1:0]         pixel;
    logic [COL_W-1:0]         col;
    logic                     kload;
    logic [IDX_W-1:0]         kidx;
    logic signed [COEF_W-1:0] kval;
  } stage1_t;

  typedef struct packed {
    meta_t                    meta;
    logic                     kload;
    logic [IDX_W-1:0]         kidx;
    logic signed [COEF_W-1:0] kval;
  } stage2_t;

  typedef struct packed {
    logic             last;
    logic             valid;
    logic [PIX_W-1:0] pix;
  } result_t;

endpackage

FILE: sv/conv2d_5x5_zero_border.sv
// 5x5 streaming convolution over 8-bit raster pixels with a signed Q4.12 kernel.
// One item (coefficient load, pixel or flush) is taken per clock, and each item
// gives exactly one result beat, through pipeline registers s1 to s5 and an
// eight-entry result queue; s_axis_tready drops only when that queue and the
// pipeline together hold eight results that m_axis has not yet taken. The
// previous four rows live in a 1024 x 32 line buffer, one entry per column,
// that each pixel reads and writes back once, so the buffer's single
// read-modify-write per cycle sets the rate at one pixel per clock. The line
// buffer needs no clearing pass after reset. Output positions run two rows and
// two pixels behind the input; positions within two pixels of an edge give
// zero, and flush beats drain the trailing positions, the last one with tlast.
// Coefficient loads take effect from the next output. The user must write image
// size through the cfg port only while the block is idle; the block does not
// enforce this. A write to either size register restarts the frame.
module conv2d_5x5_zero_border (
  input  logic                                   clk,
  input  logic                                   rst,
  // Stream in
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: pixel_in [7:0], coef_index [12:8], coef_value [28:13], zero above
  input  logic [conv5_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // tuser: command [1:0]
  input  logic [conv5_pkg::CMD_W-1:0]            s_axis_tuser,
  // Stream out
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: pixel_out [7:0]
  output logic [conv5_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // tuser: out_valid [0]
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast,
  // Configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [conv5_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [conv5_pkg::DIM_W-1:0]            cfg_data
);

  localparam int K = conv5_pkg::KERNEL_SIZE;

  // Configuration
  logic [conv5_pkg::DIM_W-1:0] image_width;
  logic [conv5_pkg::DIM_W-1:0] image_height;
  logic                        cfg_fire;
  logic                        cfg_restart;

  // Raster counters
  logic [conv5_pkg::COL_W-1:0]  col_count, col_count_next;
  logic [conv5_pkg::ROW_W-1:0]  row_count, row_count_next;
  logic [conv5_pkg::COL_W-1:0]  ocol, ocol_next;
  logic [conv5_pkg::OROW_W-1:0] orow, orow_next;

  // Pipeline
  conv5_pkg::stage1_t s1, s1_next;
  conv5_pkg::stage2_t s2;
  conv5_pkg::meta_t   s3, s4, s5;

  logic in_fire, out_fire;
  logic frame_done, do_pix, do_flush, emit, flush_last;
  logic [conv5_pkg::DIM_W-1:0] col_plus, ocol_plus;
  conv5_pkg::cmd_t cmd;

  // Line buffer
  logic [conv5_pkg::LB_W-1:0]  line_store [conv5_pkg::MAX_WIDTH];
  logic [conv5_pkg::LB_W-1:0]  lb_rdata;
  logic [conv5_pkg::LB_W-1:0]  lb_wdata;
  logic [conv5_pkg::PIX_W-1:0] lb_col [K];

  // Window, kernel and arithmetic
  logic [conv5_pkg::PIX_W-1:0]           win    [K][K];
  logic signed [conv5_pkg::COEF_W-1:0]   kernel [K][K];
  logic signed [conv5_pkg::PROD_W-1:0]   prod   [K][K];
  logic signed [conv5_pkg::ROWSUM_W-1:0] rowsum [K];
  logic signed [conv5_pkg::ROWSUM_W-1:0] rowsum_next [K];
  logic signed [conv5_pkg::SUM_W-1:0]    sum_total, sum_total_next;
  logic [conv5_pkg::SH_W-1:0]            shifted;
  logic [conv5_pkg::PIX_W-1:0]           sat_pix;

  // Result queue
  conv5_pkg::result_t         fifo_mem [conv5_pkg::FIFO_DEPTH];
  conv5_pkg::result_t         push_data;
  logic [conv5_pkg::FIFO_AW:0] wr_ptr, rd_ptr;
  logic [conv5_pkg::USED_W-1:0] used, used_next;

  function automatic logic [conv5_pkg::DIM_W-1:0] clamp_dim(
    input logic [conv5_pkg::DIM_W-1:0] v,
    input logic [conv5_pkg::DIM_W-1:0] hi
  );
    logic [conv5_pkg::DIM_W-1:0] r;
    if (v < conv5_pkg::DIM_W'(conv5_pkg::MIN_DIM)) begin
      r = conv5_pkg::DIM_W'(conv5_pkg::MIN_DIM);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready     = 1'b1;
  assign cfg_fire      = cfg_valid & cfg_ready;
  // Only the two size registers restart the frame; other indexes are ignored.
  assign cfg_restart   = cfg_fire && ((cfg_index == conv5_pkg::REG_IMAGE_WIDTH) ||
                                      (cfg_index == conv5_pkg::REG_IMAGE_HEIGHT));
  assign s_axis_tready = (used < conv5_pkg::USED_W'(conv5_pkg::FIFO_DEPTH));
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = (wr_ptr != rd_ptr);
  assign out_fire      = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= conv5_pkg::DIM_W'(conv5_pkg::DIM_RESET);
      image_height <= conv5_pkg::DIM_W'(conv5_pkg::DIM_RESET);
    end else if (cfg_fire) begin
      if (cfg_index == conv5_pkg::REG_IMAGE_WIDTH) begin
        image_width <= clamp_dim(cfg_data, conv5_pkg::DIM_W'(conv5_pkg::MAX_WIDTH));
      end
      if (cfg_index == conv5_pkg::REG_IMAGE_HEIGHT) begin
        image_height <= clamp_dim(cfg_data, conv5_pkg::DIM_W'(conv5_pkg::MAX_HEIGHT));
      end
    end
  end

  // Item decode and raster bookkeeping, all settled at the accepting edge.
  always_comb begin
    cmd        = conv5_pkg::cmd_t'(s_axis_tuser);
    frame_done = (row_count >= conv5_pkg::ROW_W'(image_height));
    do_pix     = 1'b0;
    do_flush   = 1'b0;
    s1_next    = '0;

    unique case (cmd)
      conv5_pkg::CMD_LOAD: begin
        s1_next.kload = (s_axis_tdata[conv5_pkg::PIX_W +: conv5_pkg::IDX_W] <
                         conv5_pkg::IDX_W'(conv5_pkg::KTAPS));
      end
      conv5_pkg::CMD_PIXEL: begin
        do_pix   = !frame_done;
        do_flush = frame_done;
      end
      conv5_pkg::CMD_FLUSH: begin
        do_flush = frame_done;
      end
      default: begin
      end
    endcase

    // The first output appears once the input is two rows and two pixels ahead.
    emit = (row_count > conv5_pkg::ROW_W'(conv5_pkg::KRAD)) ||
           ((row_count == conv5_pkg::ROW_W'(conv5_pkg::KRAD)) &&
            (col_count >= conv5_pkg::COL_W'(conv5_pkg::KRAD)));
    flush_last = (conv5_pkg::DIM_W'(orow) == image_height - conv5_pkg::DIM_W'(1)) &&
                 (conv5_pkg::DIM_W'(ocol) == image_width - conv5_pkg::DIM_W'(1));

    col_plus  = conv5_pkg::DIM_W'(col_count) + conv5_pkg::DIM_W'(1);
    ocol_plus = conv5_pkg::DIM_W'(ocol) + conv5_pkg::DIM_W'(1);

    col_count_next = col_count;
    row_count_next = row_count;
    ocol_next      = ocol;
    orow_next      = orow;

    if (do_pix) begin
      if (col_plus >= image_width) begin
        col_count_next = '0;
        row_count_next = row_count + conv5_pkg::ROW_W'(1);
      end else begin
        col_count_next = col_plus[conv5_pkg::COL_W-1:0];
      end
    end

    if ((do_pix && emit) || (do_flush && !flush_last)) begin
      if (ocol_plus >= image_width) begin
        ocol_next = '0;
        orow_next = orow + conv5_pkg::OROW_W'(1);
      end else begin
        ocol_next = ocol_plus[conv5_pkg::COL_W-1:0];
      end
    end

    if (do_flush && flush_last) begin
      col_count_next = '0;
      row_count_next = '0;
      ocol_next      = '0;
      orow_next      = '0;
    end

    s1_next.meta.present   = in_fire;
    s1_next.meta.out_valid = (do_pix && emit) || do_flush;
    s1_next.meta.out_last  = do_flush && flush_last;
    // A full window needs four rows and four columns of the current row behind it.
    s1_next.meta.interior  = do_pix && emit &&
                             (col_count >= conv5_pkg::COL_W'(2 * conv5_pkg::KRAD)) &&
                             (row_count >= conv5_pkg::ROW_W'(2 * conv5_pkg::KRAD));
    s1_next.pix_wr = do_pix;
    s1_next.pixel  = s_axis_tdata[conv5_pkg::PIX_W-1:0];
    s1_next.col    = col_count;
    s1_next.kidx   = s_axis_tdata[conv5_pkg::PIX_W +: conv5_pkg::IDX_W];
    s1_next.kval   = s_axis_tdata[conv5_pkg::PIX_W + conv5_pkg::IDX_W +: conv5_pkg::COEF_W];

    if (!in_fire) begin
      s1_next.meta   = '0;
      s1_next.pix_wr = 1'b0;
      s1_next.kload  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      col_count <= '0;
      row_count <= '0;
      ocol      <= '0;
      orow      <= '0;
    end else if (in_fire) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      ocol      <= ocol_next;
      orow      <= orow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
      s5 <= '0;
    end else begin
      s1 <= s1_next;
      s2 <= {s1.meta, s1.kload, s1.kidx, s1.kval};
      s3 <= s2.meta;
      s4 <= s3;
      s5 <= s4;
    end
  end

  // Line buffer read-modify-write: read at the accepting edge, write back in the
  // cycle after, from stage s1, with the new pixel pushed in and the oldest row dropped.
  always_comb begin
    lb_col[K-1] = s1.pixel;
    for (int j = 0; j < K - 1; j++) begin
      lb_col[K-2-j] = lb_rdata[j*conv5_pkg::PIX_W +: conv5_pkg::PIX_W];
    end
    lb_wdata = {lb_rdata[conv5_pkg::LB_W-conv5_pkg::PIX_W-1:0], s1.pixel};
  end

  always_ff @(posedge clk) begin
    if (s1.pix_wr) begin
      line_store[s1.col] <= lb_wdata;
    end
    if (do_pix) begin
      if (s1.pix_wr && (s1.col == col_count)) begin
        lb_rdata <= lb_wdata;
      end else begin
        lb_rdata <= line_store[col_count];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1.pix_wr) begin
      for (int m = 0; m < K; m++) begin
        for (int n = 0; n < K - 1; n++) begin
          win[m][n] <= win[m][n+1];
        end
        win[m][K-1] <= lb_col[m];
      end
    end
  end

  // Products use the kernel as it stands before a load in the same stage,
  // which keeps loads ordered against the pixels around them.
  always_ff @(posedge clk) begin
    for (int m = 0; m < K; m++) begin
      for (int n = 0; n < K; n++) begin
        prod[m][n] <= conv5_pkg::PROD_W'($signed({1'b0, win[m][n]}) * kernel[m][n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < K; m++) begin
        for (int n = 0; n < K; n++) begin
          kernel[m][n] <= '0;
        end
      end
    end else if (s2.kload) begin
      for (int m = 0; m < K; m++) begin
        for (int n = 0; n < K; n++) begin
          if (s2.kidx == conv5_pkg::IDX_W'(m * K + n)) begin
            kernel[m][n] <= s2.kval;
          end
        end
      end
    end
  end

  always_comb begin
    for (int m = 0; m < K; m++) begin
      rowsum_next[m] = '0;
      for (int n = 0; n < K; n++) begin
        rowsum_next[m] = rowsum_next[m] + conv5_pkg::ROWSUM_W'(prod[m][n]);
      end
    end
    sum_total_next = '0;
    for (int m = 0; m < K; m++) begin
      sum_total_next = sum_total_next + conv5_pkg::SUM_W'(rowsum[m]);
    end
  end

  always_ff @(posedge clk) begin
    rowsum    <= rowsum_next;
    sum_total <= sum_total_next;
  end

  // A positive sum shifts right to truncate toward zero and saturates at 255; anything else is zero.
  always_comb begin
    shifted = sum_total[conv5_pkg::SUM_W-1:conv5_pkg::COEF_FRAC_BITS];
    if (sum_total <= 0) begin
      sat_pix = '0;
    end else if (shifted > conv5_pkg::SH_W'(conv5_pkg::PIX_MAX)) begin
      sat_pix = conv5_pkg::PIX_W'(conv5_pkg::PIX_MAX);
    end else begin
      sat_pix = shifted[conv5_pkg::PIX_W-1:0];
    end
    push_data.last  = s5.out_last;
    push_data.valid = s5.out_valid;
    push_data.pix   = s5.interior ? sat_pix : '0;
  end

  // Result queue; the credit count covers both queued and in-flight results.
  always_ff @(posedge clk) begin
    if (s5.present) begin
      fifo_mem[wr_ptr[conv5_pkg::FIFO_AW-1:0]] <= push_data;
    end
  end

  assign used_next = used + conv5_pkg::USED_W'(in_fire) - conv5_pkg::USED_W'(out_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (s5.present) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      used <= used_next;
    end
  end

  assign m_axis_tdata = fifo_mem[rd_ptr[conv5_pkg::FIFO_AW-1:0]].pix;
  assign m_axis_tuser = fifo_mem[rd_ptr[conv5_pkg::FIFO_AW-1:0]].valid;
  assign m_axis_tlast = fifo_mem[rd_ptr[conv5_pkg::FIFO_AW-1:0]].last;

  // Checks
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    used <= conv5_pkg::USED_W'(conv5_pkg::FIFO_DEPTH))
    else $error("result credit count exceeds queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    conv5_pkg::USED_W'(wr_ptr - rd_ptr) <= used)
    else $error("queued results exceed outstanding credits");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1.meta.present)
    else $error("accepted item did not enter the pipeline");

  a_interior_is_output: assert property (@(posedge clk) disable iff (rst)
    (s5.present && s5.interior) |-> (s5.out_valid && !s5.out_last))
    else $error("interior result not marked as an output position");

  a_last_is_valid: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("frame end beat without out_valid");

endmodule
